// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and tables for the wheel odometry block.
// No dependencies.
package ddo_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMin = 8;
  localparam int unsigned CordicStepsMax = 24;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DIAMETER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PPR      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GEAR     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_BASE     = 2'd3;

  localparam logic [1:0] OP_RIGHT = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [21:0] PiQ20   = 22'd3294199;
  localparam logic [24:0] FullQ16 = 25'(360 << 16);
  localparam logic signed [33:0] KGainQ30 = 34'sd652032874;
  localparam logic [31:0] KCorrQ30 = 32'd434688583;

  function automatic logic signed [33:0] atan_q24(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd754974720;  5'd1: r = 34'sd445687602;
      5'd2: r = 34'sd235489088;  5'd3: r = 34'sd119537938;
      5'd4: r = 34'sd60000934;   5'd5: r = 34'sd30029717;
      5'd6: r = 34'sd15018523;   5'd7: r = 34'sd7509720;
      5'd8: r = 34'sd3754917;    5'd9: r = 34'sd1877466;
      5'd10: r = 34'sd938734;    5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;    5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;     5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;     5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;       5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;       5'd23: r = 34'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    C_IDLE, C_MUL, C_DIV, C_FWD, C_TURN, C_HEAD, C_CORDIC, C_POS, C_OUT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic       start;
    logic       edge_r;
    logic       edge_l;
    logic       down;
  } dp_ctl_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0] op;
    logic       phase_b;
  } motion_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [24:0]        heading;
    logic [31:0]        right_total;
    logic [31:0]        left_total;
  } pose_t;

endpackage

// ===== rtl/ddo_if.sv =====
// Valid/ready channel interface with payload type parameter.
// No dependencies; the payload type comes in through the parameter.
interface ddo_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ddo_ctrl.sv =====
// Sequencer for the odometry block: walks a tick through its phases.
// Depends on ddo_pkg.
module ddo_ctrl import ddo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  logic       in_phase_b_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  input  dp_sts_t    sts_i,
  output dp_ctl_t    ctl_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_FWD, S_TURN, S_HEAD, S_CORDIC, S_POS, S_OUT
  } state_e;

  state_e state_q;
  dp_ctl_t ctl_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign ctl_o = ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctl_q <= '{cmd: C_IDLE, default: '0};
    end else begin
      ctl_q <= '{cmd: C_IDLE, default: '0};
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ctl_q.down <= in_phase_b_i;
            case (in_op_i)
              OP_RIGHT: ctl_q.edge_r <= 1'b1;
              OP_LEFT:  ctl_q.edge_l <= 1'b1;
              OP_TICK: begin
                ctl_q.cmd <= C_MUL;
                state_q <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          ctl_q.cmd <= C_DIV;
          ctl_q.start <= 1'b1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          ctl_q.cmd <= C_DIV;
          if (!sts_i.busy && !ctl_q.start) begin
            ctl_q.cmd <= C_FWD;
            state_q <= S_FWD;
          end
        end
        S_FWD: begin
          ctl_q.cmd <= C_TURN;
          ctl_q.start <= 1'b1;
          state_q <= S_TURN;
        end
        S_TURN: begin
          ctl_q.cmd <= C_TURN;
          if (!sts_i.busy && !ctl_q.start) begin
            ctl_q.cmd <= C_HEAD;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          ctl_q.cmd <= C_CORDIC;
          ctl_q.start <= 1'b1;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          ctl_q.cmd <= C_CORDIC;
          if (!sts_i.busy && !ctl_q.start) begin
            ctl_q.cmd <= C_POS;
            state_q <= S_POS;
          end
        end
        S_POS: begin
          ctl_q.cmd <= C_POS;
          if (!sts_i.busy) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free_i) begin
            ctl_q.cmd <= C_OUT;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/ddo_dp.sv =====
// Datapath: counters, serial divider, position multiplier, CORDIC, pose.
// Depends on ddo_pkg; driven by ddo_ctrl.
module ddo_dp import ddo_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  dp_ctl_t             ctl_i,
  output dp_sts_t             sts_o,
  output pose_t               pose_o
);
  localparam int unsigned NRaw = (CordicSteps < CordicStepsMin) ? CordicStepsMin :
                                 (CordicSteps > CordicStepsMax) ? CordicStepsMax : CordicSteps;
  localparam logic [4:0] NSteps = 5'(NRaw);
  localparam logic signed [33:0] XInit = KGainQ30 + 34'(KCorrQ30 >> (2 * NRaw));
  localparam int unsigned DivW = 80;
  localparam logic [25:0] PiTen = 26'(10 * PiQ20);

  logic [15:0] diam_q, ppr_q, gear_q, base_q;
  logic signed [15:0] rint_q, lint_q;
  logic [31:0] rtot_q, ltot_q;
  logic signed [31:0] px_q, py_q;
  logic [24:0] head_q;

  logic sneg_q, dneg_q;
  logic [DivW-1:0] num_q, quo_q;
  logic [63:0] den_q;
  logic [64:0] rem_q;
  logic [6:0] cnt_q;
  logic busy_q;
  logic signed [32:0] fwd_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic flip_q;
  logic [1:0] mph_q;
  logic [24:0] turn_q;

  logic [15:0] ppr1, gear1, base1;
  logic [16:0] smag, dmag;
  logic signed [16:0] sum_s, dif_s;
  assign ppr1  = (ppr_q == '0) ? 16'd1 : ppr_q;
  assign gear1 = (gear_q == '0) ? 16'd1 : gear_q;
  assign base1 = (base_q == '0) ? 16'd1 : base_q;
  assign sum_s = 17'(rint_q) + 17'(lint_q);
  assign dif_s = 17'(rint_q) - 17'(lint_q);
  assign smag  = sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
  assign dmag  = dif_s[16] ? 17'(-dif_s) : 17'(dif_s);

  // shared count times diameter product
  logic [16:0] mag;
  logic [32:0] mprod;
  assign mag   = (ctl_i.cmd == C_MUL) ? smag : dmag;
  assign mprod = mag * diam_q;

  // restoring divide step
  logic [64:0] rem_sh;
  logic rem_ge;
  assign rem_sh = {rem_q[63:0], num_q[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // rounding quotient: q + (r >= d - r)
  logic rbit;
  logic [DivW-1:0] qround;
  assign rbit   = rem_q >= (65'(den_q) - rem_q);
  assign qround = quo_q + DivW'(rbit);

  // quotient modulo a full turn, accumulated as quotient bits arrive
  logic [25:0] tacc, tinc;
  assign tacc = {turn_q, rem_ge};
  assign tinc = {1'b0, turn_q} + 26'(rbit);

  // cordic step
  logic signed [33:0] xs, ys;
  logic [4:0] ci;
  assign ci = cnt_q[4:0];
  assign xs = cx_q >>> ci;
  assign ys = cy_q >>> ci;

  // position multiply: fwd (33b) * cos or sin (34b), one axis per cycle
  logic signed [66:0] prod;
  logic [65:0] pmag;
  logic signed [66:0] rnd;
  logic signed [33:0] fac;
  assign fac  = mph_q[0] ? cy_q : cx_q;
  assign prod = 67'(fwd_q) * 67'(fac);
  assign pmag = prod[66] ? 66'(-prod) : 66'(prod);
  assign rnd  = prod[66] ? -67'((pmag + 66'(1 << 29)) >> 30)
                         : 67'((pmag + 66'(1 << 29)) >> 30);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [26:0] hsum;
  logic [24:0] turn;
  assign turn = (tinc >= 26'(FullQ16)) ? 25'(tinc - 26'(FullQ16)) : 25'(tinc);

  assign sts_o.busy = busy_q;
  assign pose_o = '{pos_x: px_q, pos_y: py_q, heading: head_q,
                    right_total: rtot_q, left_total: ltot_q};

  logic signed [33:0] zang;
  assign zang = $signed({1'b0, head_q, 8'b0});
  assign hsum = dneg_q ? 27'(head_q) - 27'(turn) : 27'(head_q) + 27'(turn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= 16'd15360; ppr_q <= 16'd512; gear_q <= 16'd6400; base_q <= 16'd7680;
      rint_q <= '0; lint_q <= '0; rtot_q <= '0; ltot_q <= '0;
      px_q <= '0; py_q <= '0; head_q <= '0; busy_q <= 1'b0;
      sneg_q <= 1'b0; dneg_q <= 1'b0; num_q <= '0; quo_q <= '0; den_q <= '0;
      rem_q <= '0; cnt_q <= '0; fwd_q <= '0; cx_q <= '0; cy_q <= '0; cz_q <= '0;
      flip_q <= 1'b0; mph_q <= '0; turn_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIAMETER: diam_q <= cfg_data_i;
          CFG_PPR:      ppr_q <= cfg_data_i;
          CFG_GEAR:     gear_q <= cfg_data_i;
          CFG_BASE:     base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.edge_r) begin
        rtot_q <= rtot_q + 32'd1;
        if (ctl_i.down) rint_q <= (rint_q != 16'sh8000) ? rint_q - 16'sd1 : rint_q;
        else rint_q <= (rint_q != 16'sh7fff) ? rint_q + 16'sd1 : rint_q;
      end
      if (ctl_i.edge_l) begin
        ltot_q <= ltot_q + 32'd1;
        if (ctl_i.down) lint_q <= (lint_q != 16'sh8000) ? lint_q - 16'sd1 : lint_q;
        else lint_q <= (lint_q != 16'sh7fff) ? lint_q + 16'sd1 : lint_q;
      end
      case (ctl_i.cmd)
        C_MUL: begin
          sneg_q <= sum_s[16];
          dneg_q <= dif_s[16];
          num_q <= DivW'(mprod) * DivW'(PiTen);
          den_q <= 64'(32'(ppr1 * gear1)) << 13;
        end
        C_DIV: begin
          if (ctl_i.start) begin
            busy_q <= 1'b1; cnt_q <= '0; rem_q <= '0; quo_q <= '0;
          end else if (busy_q) begin
            rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
            quo_q <= {quo_q[DivW-2:0], rem_ge};
            num_q <= num_q << 1;
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'(DivW - 1)) busy_q <= 1'b0;
          end
        end
        C_FWD: begin
          fwd_q <= sneg_q ? -33'((qround > 80'h7fffffff) ? 80'h7fffffff : qround)
                          : 33'((qround > 80'h7fffffff) ? 80'h7fffffff : qround);
          num_q <= DivW'({41'(mprod) * 41'(180), 24'b0});
          den_q <= 64'(den_q[44:13] * base1);
        end
        C_TURN: begin
          if (ctl_i.start) begin
            busy_q <= 1'b1; cnt_q <= '0; rem_q <= '0; quo_q <= '0; turn_q <= '0;
          end else if (busy_q) begin
            rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
            quo_q <= {quo_q[DivW-2:0], rem_ge};
            turn_q <= (tacc >= 26'(FullQ16)) ? 25'(tacc - 26'(FullQ16)) : 25'(tacc);
            num_q <= num_q << 1;
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'(DivW - 1)) busy_q <= 1'b0;
          end
        end
        C_HEAD: begin
          if (hsum < 0) head_q <= 25'(hsum + 27'(FullQ16));
          else if (hsum >= 27'(FullQ16)) head_q <= 25'(hsum - 27'(FullQ16));
          else head_q <= 25'(hsum);
        end
        C_CORDIC: begin
          if (ctl_i.start) begin
            busy_q <= 1'b1; cnt_q <= '0; cx_q <= XInit; cy_q <= '0; flip_q <= 1'b0;
            begin
              if (zang > 34'sd3019898880 - 34'sd3019898880 + (34'sd180 <<< 24)) begin
                if (zang - (34'sd360 <<< 24) < -(34'sd90 <<< 24)) begin
                  cz_q <= zang - (34'sd180 <<< 24); flip_q <= 1'b1;
                end else cz_q <= zang - (34'sd360 <<< 24);
              end else if (zang > (34'sd90 <<< 24)) begin
                cz_q <= zang - (34'sd180 <<< 24); flip_q <= 1'b1;
              end else cz_q <= zang;
            end
          end else if (busy_q) begin
            if (!cz_q[33]) begin
              cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atan_q24(ci);
            end else begin
              cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atan_q24(ci);
            end
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q[4:0] == NSteps - 5'd1) busy_q <= 1'b0;
          end else if (flip_q) begin
            cx_q <= -cx_q; cy_q <= -cy_q; flip_q <= 1'b0;
          end
          mph_q <= '0;
        end
        C_POS: begin
          busy_q <= 1'b1;
          mph_q <= mph_q + 2'd1;
          if (mph_q == 2'd0) px_q <= sat32(68'(px_q) + 68'(rnd));
          if (mph_q == 2'd1) begin
            py_q <= sat32(68'(py_q) + 68'(rnd));
            busy_q <= 1'b0;
            rint_q <= '0; lint_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/differential_drive_odometry.sv =====
// channel  dir  payload                                        transfer
// in       in   op[1:0], phase_b                               valid & ready
// out      out  pos_x, pos_y, heading, right_total, left_total valid & ready
// cfg      in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[15:0]     cfg_we_i
// Edges transfer every cycle while no tick is in progress. A tick holds the
// input until its pose is registered on out, mostly spent in two 80-step
// bit-serial divides plus the CORDIC.
// Reset restores the default geometry and clears counts and pose.
// A pending result holds the block until out.ready. Depends on ddo_pkg, ddo_if, ddo_ctrl, ddo_dp.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ddo_if.sink                 in_ch,
  ddo_if.source               out_ch
);
  dp_ctl_t ctl;
  dp_sts_t sts;
  pose_t pose;
  logic out_valid_q;
  pose_t out_q;

  ddo_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_op_i(in_ch.data.op),
    .in_phase_b_i(in_ch.data.phase_b), .in_ready_o(in_ch.ready),
    .out_free_i(!out_valid_q || out_ch.ready), .sts_i(sts), .ctl_o(ctl)
  );

  ddo_dp #(.CordicSteps(CordicSteps)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ctl_i(ctl), .sts_o(sts), .pose_o(pose)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.cmd == C_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.cmd == C_OUT) out_q <= pose;
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data = out_q;
endmodule
